// ----- sv/mbm_pkg.sv -----
`timescale 1ns / 1ps

package mbm_pkg;

   // Register decode of CPU writes in the $8000-$FFFF window
   localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
   localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
   localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
   localparam logic [15:0] REG_MIRRORING   = 16'hA000;
   localparam logic [15:0] REG_LINE_LATCH  = 16'hC000;
   localparam logic [15:0] REG_LINE_RELOAD = 16'hC001;
   localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
   localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

   localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

   localparam logic [1:0] MIRROR_VERTICAL    = 2'd0;
   localparam logic [1:0] MIRROR_HORIZONTAL  = 2'd1;
   localparam logic [1:0] MIRROR_FOUR_SCREEN = 2'd2;

   typedef enum logic [1:0] {
      OP_REG_WRITE   = 2'd0,
      OP_OUTER_WRITE = 2'd1,
      OP_LINE_TICK   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_PRG_BANK_COUNT   = 2'd0,
      CSR_CHR_ROM_PRESENT  = 2'd1,
      CSR_HEADER_MIRRORING = 2'd2
   } csr_index_type;

   // Target of a bank data write, chosen by the low bits of bank select
   typedef enum logic [2:0] {
      SEL_CHR_PAIR0   = 3'd0,
      SEL_CHR_PAIR1   = 3'd1,
      SEL_CHR_SINGLE0 = 3'd2,
      SEL_CHR_SINGLE1 = 3'd3,
      SEL_CHR_SINGLE2 = 3'd4,
      SEL_CHR_SINGLE3 = 3'd5,
      SEL_PRG_FIRST   = 3'd6,
      SEL_PRG_SECOND  = 3'd7
   } bank_target_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [8:0]  line_number;
      logic        rendering_on;
   } req_type;

   typedef struct packed {
      logic [8:0] prg_bank_count;
      logic       chr_rom_present;
      logic [1:0] header_mirroring;
   } cfg_type;

   typedef struct packed {
      logic [7:0]       bank_select;
      logic             outer_locked;
      logic [7:0]       outer_bank;
      logic [7:0]       prg_select_first;
      logic [7:0]       prg_select_second;
      logic [1:0][7:0]  chr_pair_banks;
      logic [3:0][7:0]  chr_single_banks;
      logic             line_irq_enable;
      logic [7:0]       line_count;
      logic [7:0]       line_reload;
      logic             mirror_horizontal;
   } state_type;

   typedef struct packed {
      logic [27:0] prg_banks;
      logic [39:0] chr_banks_low;
      logic [39:0] chr_banks_high;
      logic [1:0]  mirror_mode;
      logic        irq_pulse;
   } rsp_type;

endpackage

// ----- sv/mbm_if.sv -----
`timescale 1ns / 1ps

interface mbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [8:0]  line_number;
   logic        rendering_on;

   modport source (output valid, output operation, output address, output write_data,
                   output line_number, output rendering_on, input ready);
   modport sink   (input valid, input operation, input address, input write_data,
                   input line_number, input rendering_on, output ready);
endinterface

interface mbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [27:0] prg_banks;
   logic [39:0] chr_banks_low;
   logic [39:0] chr_banks_high;
   logic [1:0]  mirror_mode;
   logic        irq_pulse;

   modport source (output valid, output prg_banks, output chr_banks_low,
                   output chr_banks_high, output mirror_mode, output irq_pulse,
                   input ready);
   modport sink   (input valid, input prg_banks, input chr_banks_low,
                   input chr_banks_high, input mirror_mode, input irq_pulse,
                   output ready);
endinterface

interface mbm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [8:0] write_data;

   modport source (output valid, output index, output write_data, input ready);
   modport sink   (input valid, input index, input write_data, output ready);
endinterface

// ----- sv/mbm_regs.sv -----
`timescale 1ns / 1ps

module mbm_regs import mbm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  req_type    step_req,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data,
   output cfg_type    cfg,
   output state_type  state_next,
   output logic       irq_next
);

   localparam state_type STATE_RESET = '{
      bank_select:       8'd0,
      outer_locked:      1'b0,
      outer_bank:        8'd0,
      prg_select_first:  8'd0,
      prg_select_second: 8'd1,
      chr_pair_banks:    {8'd2, 8'd0},
      chr_single_banks:  {8'd7, 8'd6, 8'd5, 8'd4},
      line_irq_enable:   1'b0,
      line_count:        8'd0,
      line_reload:       8'd0,
      mirror_horizontal: 1'b0
   };

   localparam cfg_type CFG_RESET = '{
      prg_bank_count:   9'd32,
      chr_rom_present:  1'b1,
      header_mirroring: MIRROR_VERTICAL
   };

   state_type state_ff, state_in, step_state;
   cfg_type   cfg_ff, cfg_in;
   logic      pulse;

   // State after the item now leaving the input register.
   always_comb begin
      step_state = state_ff;
      pulse      = 1'b0;
      case (step_req.operation)
         OP_REG_WRITE: begin
            case (step_req.address & REG_DECODE_MASK)
               REG_BANK_SELECT: step_state.bank_select = step_req.write_data;
               REG_BANK_DATA: begin
                  case (bank_target_type'(state_ff.bank_select[2:0]))
                     SEL_CHR_PAIR0: if (cfg_ff.chr_rom_present) begin
                        step_state.chr_pair_banks[0] = {step_req.write_data[7:1], 1'b0};
                     end
                     SEL_CHR_PAIR1: if (cfg_ff.chr_rom_present) begin
                        step_state.chr_pair_banks[1] = {step_req.write_data[7:1], 1'b0};
                     end
                     SEL_CHR_SINGLE0: if (cfg_ff.chr_rom_present) begin
                        step_state.chr_single_banks[0] = step_req.write_data;
                     end
                     SEL_CHR_SINGLE1: if (cfg_ff.chr_rom_present) begin
                        step_state.chr_single_banks[1] = step_req.write_data;
                     end
                     SEL_CHR_SINGLE2: if (cfg_ff.chr_rom_present) begin
                        step_state.chr_single_banks[2] = step_req.write_data;
                     end
                     SEL_CHR_SINGLE3: if (cfg_ff.chr_rom_present) begin
                        step_state.chr_single_banks[3] = step_req.write_data;
                     end
                     SEL_PRG_FIRST: step_state.prg_select_first = step_req.write_data;
                     default: step_state.prg_select_second = step_req.write_data;
                  endcase
               end
               REG_MIRRORING: if (cfg_ff.header_mirroring != MIRROR_FOUR_SCREEN) begin
                  step_state.mirror_horizontal = step_req.write_data[0];
               end
               REG_LINE_LATCH:  step_state.line_count      = step_req.write_data;
               REG_LINE_RELOAD: step_state.line_reload     = step_req.write_data;
               REG_IRQ_DISABLE: step_state.line_irq_enable = 1'b0;
               REG_IRQ_ENABLE:  step_state.line_irq_enable = 1'b1;
               default: ;
            endcase
         end
         OP_OUTER_WRITE: if (!state_ff.outer_locked) begin
            step_state.outer_locked = 1'b1;
            step_state.outer_bank   = step_req.write_data;
         end
         OP_LINE_TICK: begin
            if (state_ff.line_irq_enable && (step_req.line_number <= LAST_VISIBLE_LINE) &&
                step_req.rendering_on) begin
               if (state_ff.line_count == 8'd0) begin
                  step_state.line_count = state_ff.line_reload;
                  pulse                 = 1'b1;
               end else begin
                  step_state.line_count = state_ff.line_count - 8'd1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = step_valid ? step_state : state_ff;
      cfg_in   = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PRG_BANK_COUNT:  cfg_in.prg_bank_count  = csr_data;
            CSR_CHR_ROM_PRESENT: cfg_in.chr_rom_present = csr_data[0];
            CSR_HEADER_MIRRORING: begin
               cfg_in.header_mirroring     = csr_data[1:0];
               state_in.mirror_horizontal  = (csr_data[1:0] == MIRROR_HORIZONTAL);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         cfg_ff   <= CFG_RESET;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
      end
   end

   assign cfg        = cfg_ff;
   assign state_next = step_state;
   assign irq_next   = pulse;

endmodule

// ----- sv/mbm_map.sv -----
`timescale 1ns / 1ps

module mbm_map import mbm_pkg::*; (
   input  cfg_type   cfg,
   input  state_type state,
   input  logic      irq,
   output rsp_type   rsp
);

   logic [4:0]      prg_mask;
   logic [6:0]      prg_base;
   logic [8:0]      last_bank, second_last_bank;
   logic [3:0][8:0] prg_sel;
   logic [7:0]      chr_mask;
   logic [2:0]      chr_base;
   logic [3:0][7:0] pairs;
   logic [7:0][7:0] chr_sel;
   logic [3:0][6:0] prg_slots;
   logic [7:0][9:0] chr_slots;

   always_comb begin
      // Outer bank bit 3 picks a 128K program window instead of 256K.
      if (state.outer_bank[3]) begin
         prg_mask = 5'h0F;
         prg_base = {state.outer_bank[2:0], 4'b0000};
      end else begin
         prg_mask = 5'h1F;
         prg_base = {state.outer_bank[2:1], 5'b00000};
      end

      last_bank        = cfg.prg_bank_count - 9'd1;
      second_last_bank = cfg.prg_bank_count - 9'd2;

      if (state.bank_select[6]) begin
         prg_sel[0] = second_last_bank;
         prg_sel[1] = {1'b0, state.prg_select_second};
         prg_sel[2] = {1'b0, state.prg_select_first};
      end else begin
         prg_sel[0] = {1'b0, state.prg_select_first};
         prg_sel[1] = {1'b0, state.prg_select_second};
         prg_sel[2] = second_last_bank;
      end
      prg_sel[3] = last_bank;

      for (int i = 0; i < 4; i++) begin
         prg_slots[i] = prg_base | {2'b00, prg_mask & prg_sel[i][4:0]};
      end

      // Outer bank bit 6 halves the pattern window and brings in bit 2.
      chr_mask = state.outer_bank[6] ? 8'h7F : 8'hFF;
      chr_base = {state.outer_bank[5], state.outer_bank[6] & state.outer_bank[2],
                  state.outer_bank[4]};

      pairs[0] = state.chr_pair_banks[0];
      pairs[1] = state.chr_pair_banks[0] + 8'd1;
      pairs[2] = state.chr_pair_banks[1];
      pairs[3] = state.chr_pair_banks[1] + 8'd1;

      for (int i = 0; i < 4; i++) begin
         if (state.bank_select[7]) begin
            chr_sel[i]     = state.chr_single_banks[i];
            chr_sel[i + 4] = pairs[i];
         end else begin
            chr_sel[i]     = pairs[i];
            chr_sel[i + 4] = state.chr_single_banks[i];
         end
      end

      for (int i = 0; i < 8; i++) begin
         chr_slots[i] = {chr_base, 7'b0000000} | {2'b00, chr_mask & chr_sel[i]};
      end

      rsp.prg_banks      = prg_slots;
      rsp.chr_banks_low  = {chr_slots[3], chr_slots[2], chr_slots[1], chr_slots[0]};
      rsp.chr_banks_high = {chr_slots[7], chr_slots[6], chr_slots[5], chr_slots[4]};
      rsp.mirror_mode    = (cfg.header_mirroring == MIRROR_FOUR_SCREEN) ?
                           MIRROR_FOUR_SCREEN : {1'b0, state.mirror_horizontal};
      rsp.irq_pulse      = irq;
   end

endmodule

// ----- sv/multicart_bank_mapper_with_line_irq.sv -----
`timescale 1ns / 1ps

// Bank mapper for a multicart board with a scanline interrupt counter.
// req_bus carries one beat per CPU write ($8000-$FFFF register write or
// $6000-$7FFF outer bank write) or per scanline tick. Every accepted beat
// yields exactly one rsp_bus beat with the full bank map after that item:
// four program bank numbers, eight pattern bank numbers, the mirroring mode
// and an interrupt pulse that is high only for the tick that fires.
// csr_bus writes the three board settings (program bank count, pattern ROM
// present, header mirroring); it is always ready. It must be written only while
// no item is in flight; the block itself does not enforce this.
// An accepted beat passes through the input register and the result register
// to rsp_bus. Throughput is one item per cycle while rsp_bus takes beats, set by
// the single decode-and-map pass between the input register and the result
// register. A stalled rsp_bus holds its beat; the input register still
// takes one more beat, and req_bus.ready drops once both registers are full.
// Synchronous reset empties both registers and returns every bank register,
// the outer lock and the line counter to their power-on values.
module multicart_bank_mapper_with_line_irq import mbm_pkg::*; (
   input logic      clock,
   input logic      reset,
   mbm_req_if.sink   req_bus,
   mbm_rsp_if.source rsp_bus,
   mbm_csr_if.sink   csr_bus
);

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_req_ff;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_ff;
   logic      req_accept, advance;
   cfg_type   cfg;
   state_type state_next;
   logic      irq_next;
   rsp_type   map_rsp;

   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_accept   = req_bus.valid && req_bus.ready;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= '{operation:    req_bus.operation,
                        address:      req_bus.address,
                        write_data:   req_bus.write_data,
                        line_number:  req_bus.line_number,
                        rendering_on: req_bus.rendering_on};
      end
      if (advance) begin
         out_ff <= map_rsp;
      end
   end

   mbm_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_req   (s1_req_ff),
      .csr_write  (csr_bus.valid),
      .csr_index  (csr_bus.index),
      .csr_data   (csr_bus.write_data),
      .cfg        (cfg),
      .state_next (state_next),
      .irq_next   (irq_next)
   );

   mbm_map u_map (
      .cfg   (cfg),
      .state (state_next),
      .irq   (irq_next),
      .rsp   (map_rsp)
   );

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.prg_banks      = out_ff.prg_banks;
   assign rsp_bus.chr_banks_low  = out_ff.chr_banks_low;
   assign rsp_bus.chr_banks_high = out_ff.chr_banks_high;
   assign rsp_bus.mirror_mode    = out_ff.mirror_mode;
   assign rsp_bus.irq_pulse      = out_ff.irq_pulse;

endmodule

// ----- sv/mbm_checker.sv -----
`timescale 1ns / 1ps

module mbm_checker import mbm_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [27:0] rsp_prg_banks,
   input logic [1:0]  rsp_mirror_mode
);

   // Nothing is left in the result register after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present right after reset");

   // A stalled result beat stays and keeps its program bank numbers.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prg_banks))
      else $error("stalled result beat dropped or changed");

   // An accepted item passes through the input register to the output if the sink takes beats.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted item did not produce a result in time");

   a_mirror_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mirror_mode == MIRROR_VERTICAL ||
                     rsp_mirror_mode == MIRROR_HORIZONTAL ||
                     rsp_mirror_mode == MIRROR_FOUR_SCREEN))
      else $error("mirroring mode out of range");

endmodule

bind multicart_bank_mapper_with_line_irq mbm_checker u_mbm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_prg_banks   (rsp_bus.prg_banks),
   .rsp_mirror_mode (rsp_bus.mirror_mode)
);
